/* src/limit_order_book_matcher_assert.svh */
// Assertion macros for the limit order book matcher.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

`define LOBM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("limit order book matcher check failed");

`define LOBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("limit order book matcher check failed");

`endif

/* src/lobm_pkg.sv */
// Shared types and constants of the limit order book matcher.
// No dependencies.
`default_nettype none
package lobm_pkg;
    localparam int ORDER_SLOTS = 32;
    localparam int IDX_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_CANCEL = 3'd1;
    localparam logic [2:0] OP_MODIFY = 3'd2;
    localparam logic [2:0] OP_MARKET = 3'd3;
    localparam logic [2:0] OP_IOC    = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_TRADE  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [63:0] ord_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] remaining;
        logic [31:0] arrival;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_APPLY = 6'b000100,
        S_BOOK  = 6'b001000,
        S_CLOSE = 6'b010000,
        S_START = 6'b100000
    } state_t;
endpackage
`default_nettype wire

/* src/lobm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/limit_order_book_matcher.sv */
// Top level of the limit order book matcher: slot RAM, scan sequencer, matching.
// Depends on lobm_pkg, lobm_ram and limit_order_book_matcher_assert.svh.
//
//  Channel | Handshake           | Word
//  in      | in_valid / in_ready | opcode, ord_id, side, price, quantity, timestamp
//  out     | out_valid/out_ready | status, maker_id, trade and book fields, last
//
// A command runs a lookup scan through the RAM read port, an apply state and a
// top-of-book scan, after which its closing word is sent.
// Each fill adds a write back and a rescan; a zero-quantity market or IOC order and
// an unknown opcode skip the lookup scan and close after the top-of-book scan.
// After reset the book is empty at once; no clearing pass is needed.
// A stalled output holds the sequencer before the next word is loaded.
`default_nettype none
module limit_order_book_matcher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [63:0] ord_id,
    input  wire logic        side,
    input  wire logic [31:0] price,
    input  wire logic [31:0] quantity,
    input  wire logic [63:0] timestamp,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [63:0]      maker_id,
    output logic [31:0]      trade_price,
    output logic [31:0]      trade_qty,
    output logic [63:0]      trade_time,
    output logic [31:0]      fill_total,
    output logic [31:0]      best_bid,
    output logic [31:0]      best_ask,
    output logic [31:0]      best_bid_qty,
    output logic [31:0]      best_ask_qty,
    output logic             crossed,
    output logic             last
);
`include "limit_order_book_matcher_assert.svh"

    localparam int N = lobm_pkg::ORDER_SLOTS;
    localparam int IW = lobm_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

    lobm_pkg::state_t state_reg, state_next;
    logic [N-1:0]  valid_reg, valid_next;
    logic [31:0]   arr_cnt_reg, arr_cnt_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          iss_reg, iss_next;
    logic          dv_reg, dv_next;
    logic [IW-1:0] d_idx_reg, d_idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          go_book_reg, go_book_next;

    logic [2:0]  op_reg, op_next;
    logic [63:0] id_reg, id_next;
    logic        side_reg, side_next;
    logic [31:0] price_reg, price_next;
    logic [31:0] qty_reg, qty_next;
    logic [63:0] ts_reg, ts_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] filled_reg, filled_next;
    logic [1:0]  stat_reg, stat_next;

    logic          fm_found_reg, fm_found_next;
    logic [IW-1:0] fm_idx_reg, fm_idx_next;
    logic          fm_side_reg, fm_side_next;

    logic          bs_found_reg, bs_found_next;
    logic [IW-1:0] bs_idx_reg, bs_idx_next;
    lobm_pkg::slot_t bs_reg, bs_next;
    logic [31:0]   bs_age_reg, bs_age_next;

    logic        tb_f_reg, tb_f_next, ta_f_reg, ta_f_next;
    logic [31:0] tb_p_reg, tb_p_next, ta_p_reg, ta_p_next;
    logic [31:0] tb_q_reg, tb_q_next, ta_q_reg, ta_q_next;

    logic [1:0]  o_stat_reg, o_stat_next;
    logic [63:0] o_maker_reg, o_maker_next;
    logic [31:0] o_tp_reg, o_tp_next, o_tq_reg, o_tq_next;
    logic [63:0] o_tt_reg, o_tt_next;
    logic [31:0] o_fill_reg, o_fill_next;
    logic [31:0] o_bb_reg, o_bb_next, o_ba_reg, o_ba_next;
    logic [31:0] o_bbq_reg, o_bbq_next, o_baq_reg, o_baq_next;
    logic        o_cr_reg, o_cr_next, o_last_reg, o_last_next;

    logic            we;
    logic [IW-1:0]   waddr;
    lobm_pkg::slot_t wdata;
    lobm_pkg::slot_t rd;
    logic [lobm_pkg::SLOT_W-1:0] rdata;

    logic          free_found;
    logic [IW-1:0] free_idx;
    logic          rs;
    logic          d_v;
    logic [31:0]   age;
    logic          elig, better;
    logic [32:0]   sum_b, sum_a;
    logic          out_free;
    logic [31:0]   ex;

    lobm_ram #(.WIDTH(lobm_pkg::SLOT_W), .DEPTH(N)) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    assign rd = lobm_pkg::slot_t'(rdata);
    assign d_v = valid_reg[d_idx_reg] & dv_reg;
    assign rs = ~side_reg;
    assign age = arr_cnt_reg - rd.arrival;
    assign out_free = !out_valid_reg || out_ready;
    assign ex = (left_reg < bs_reg.remaining) ? left_reg : bs_reg.remaining;
    assign sum_b = {1'b0, tb_q_reg} + {1'b0, rd.remaining};
    assign sum_a = {1'b0, ta_q_reg} + {1'b0, rd.remaining};

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        elig = d_v && (rd.side == rs) &&
               !((op_reg == lobm_pkg::OP_IOC) &&
                 (rs ? (rd.price > price_reg) : (rd.price < price_reg)));
        better = !bs_found_reg ||
                 (rs ? (rd.price < bs_reg.price) : (rd.price > bs_reg.price)) ||
                 ((rd.price == bs_reg.price) && (age > bs_age_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        arr_cnt_next = arr_cnt_reg;
        rd_idx_next = rd_idx_reg;
        iss_next = iss_reg;
        dv_next = 1'b0;
        d_idx_next = rd_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        go_book_next = go_book_reg;
        op_next = op_reg;
        id_next = id_reg;
        side_next = side_reg;
        price_next = price_reg;
        qty_next = qty_reg;
        ts_next = ts_reg;
        left_next = left_reg;
        filled_next = filled_reg;
        stat_next = stat_reg;
        fm_found_next = fm_found_reg;
        fm_idx_next = fm_idx_reg;
        fm_side_next = fm_side_reg;
        bs_found_next = bs_found_reg;
        bs_idx_next = bs_idx_reg;
        bs_next = bs_reg;
        bs_age_next = bs_age_reg;
        tb_f_next = tb_f_reg;
        tb_p_next = tb_p_reg;
        tb_q_next = tb_q_reg;
        ta_f_next = ta_f_reg;
        ta_p_next = ta_p_reg;
        ta_q_next = ta_q_reg;
        o_stat_next = o_stat_reg;
        o_maker_next = o_maker_reg;
        o_tp_next = o_tp_reg;
        o_tq_next = o_tq_reg;
        o_tt_next = o_tt_reg;
        o_fill_next = o_fill_reg;
        o_bb_next = o_bb_reg;
        o_ba_next = o_ba_reg;
        o_bbq_next = o_bbq_reg;
        o_baq_next = o_baq_reg;
        o_cr_next = o_cr_reg;
        o_last_next = o_last_reg;
        we = 1'b0;
        waddr = bs_idx_reg;
        wdata = bs_reg;

        unique case (state_reg)
            lobm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = opcode;
                    id_next = ord_id;
                    side_next = side;
                    price_next = price;
                    qty_next = quantity;
                    ts_next = timestamp;
                    left_next = quantity;
                    filled_next = '0;
                    stat_next = lobm_pkg::ST_DONE;
                    go_book_next = 1'b0;
                    if (opcode > lobm_pkg::OP_IOC)
                    begin
                        stat_next = lobm_pkg::ST_REJECT;
                        go_book_next = 1'b1;
                    end
                    else if ((opcode == lobm_pkg::OP_MARKET || opcode == lobm_pkg::OP_IOC)
                             && quantity == '0)
                    begin
                        go_book_next = 1'b1;
                    end
                    state_next = lobm_pkg::S_START;
                end
            end
            lobm_pkg::S_START:
            begin
                rd_idx_next = '0;
                iss_next = 1'b1;
                fm_found_next = 1'b0;
                bs_found_next = 1'b0;
                tb_f_next = 1'b0;
                ta_f_next = 1'b0;
                tb_p_next = '0;
                ta_p_next = '0;
                tb_q_next = '0;
                ta_q_next = '0;
                state_next = go_book_reg ? lobm_pkg::S_BOOK : lobm_pkg::S_SCAN;
            end
            lobm_pkg::S_SCAN:
            begin
                dv_next = iss_reg;
                rd_idx_next = rd_idx_reg + IW'(1);
                iss_next = iss_reg && (rd_idx_reg != LAST_IDX);
                if (d_v && rd.ord_id == id_reg && !fm_found_reg)
                begin
                    fm_found_next = 1'b1;
                    fm_idx_next = d_idx_reg;
                    fm_side_next = rd.side;
                end
                if (elig && better)
                begin
                    bs_found_next = 1'b1;
                    bs_idx_next = d_idx_reg;
                    bs_next = rd;
                    bs_age_next = age;
                end
                if (dv_reg && d_idx_reg == LAST_IDX)
                begin
                    state_next = lobm_pkg::S_APPLY;
                end
            end
            lobm_pkg::S_APPLY:
            begin
                go_book_next = 1'b1;
                state_next = lobm_pkg::S_START;
                priority if (op_reg == lobm_pkg::OP_ADD)
                begin
                    if (qty_reg == '0 || fm_found_reg)
                    begin
                        stat_next = lobm_pkg::ST_REJECT;
                    end
                    else if (!free_found)
                    begin
                        stat_next = lobm_pkg::ST_FULL;
                    end
                    else
                    begin
                        we = 1'b1;
                        waddr = free_idx;
                        wdata = '{ord_id: id_reg, side: side_reg, price: price_reg,
                                  remaining: qty_reg, arrival: arr_cnt_reg};
                        valid_next[free_idx] = 1'b1;
                        arr_cnt_next = arr_cnt_reg + 32'd1;
                    end
                end
                else if (op_reg == lobm_pkg::OP_CANCEL)
                begin
                    if (fm_found_reg)
                    begin
                        valid_next[fm_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        stat_next = lobm_pkg::ST_REJECT;
                    end
                end
                else if (op_reg == lobm_pkg::OP_MODIFY)
                begin
                    if (fm_found_reg && qty_reg != '0)
                    begin
                        we = 1'b1;
                        waddr = fm_idx_reg;
                        wdata = '{ord_id: id_reg, side: fm_side_reg, price: price_reg,
                                  remaining: qty_reg, arrival: arr_cnt_reg};
                        arr_cnt_next = arr_cnt_reg + 32'd1;
                    end
                    else
                    begin
                        stat_next = lobm_pkg::ST_REJECT;
                    end
                end
                else
                begin
                    if (bs_found_reg)
                    begin
                        if (out_free)
                        begin
                            we = 1'b1;
                            waddr = bs_idx_reg;
                            wdata = bs_reg;
                            wdata.remaining = bs_reg.remaining - ex;
                            if (bs_reg.remaining == ex)
                            begin
                                valid_next[bs_idx_reg] = 1'b0;
                            end
                            left_next = left_reg - ex;
                            filled_next = filled_reg + ex;
                            go_book_next = (left_reg == ex);
                            out_valid_next = 1'b1;
                            o_stat_next = lobm_pkg::ST_TRADE;
                            o_maker_next = bs_reg.ord_id;
                            o_tp_next = bs_reg.price;
                            o_tq_next = ex;
                            o_tt_next = ts_reg;
                            o_fill_next = '0;
                            o_bb_next = '0;
                            o_ba_next = '0;
                            o_bbq_next = '0;
                            o_baq_next = '0;
                            o_cr_next = 1'b0;
                            o_last_next = 1'b0;
                        end
                        else
                        begin
                            state_next = lobm_pkg::S_APPLY;
                        end
                    end
                end
            end
            lobm_pkg::S_BOOK:
            begin
                dv_next = iss_reg;
                rd_idx_next = rd_idx_reg + IW'(1);
                iss_next = iss_reg && (rd_idx_reg != LAST_IDX);
                if (d_v && !rd.side)
                begin
                    if (!tb_f_reg || rd.price > tb_p_reg)
                    begin
                        tb_f_next = 1'b1;
                        tb_p_next = rd.price;
                        tb_q_next = rd.remaining;
                    end
                    else if (rd.price == tb_p_reg)
                    begin
                        tb_q_next = sum_b[32] ? 32'hFFFF_FFFF : sum_b[31:0];
                    end
                end
                if (d_v && rd.side)
                begin
                    if (!ta_f_reg || rd.price < ta_p_reg)
                    begin
                        ta_f_next = 1'b1;
                        ta_p_next = rd.price;
                        ta_q_next = rd.remaining;
                    end
                    else if (rd.price == ta_p_reg)
                    begin
                        ta_q_next = sum_a[32] ? 32'hFFFF_FFFF : sum_a[31:0];
                    end
                end
                if (dv_reg && d_idx_reg == LAST_IDX)
                begin
                    state_next = lobm_pkg::S_CLOSE;
                end
            end
            lobm_pkg::S_CLOSE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_stat_next = stat_reg;
                    o_maker_next = '0;
                    o_tp_next = '0;
                    o_tq_next = '0;
                    o_tt_next = '0;
                    o_fill_next = filled_reg;
                    o_bb_next = tb_p_reg;
                    o_ba_next = ta_p_reg;
                    o_bbq_next = tb_q_reg;
                    o_baq_next = ta_q_reg;
                    o_cr_next = tb_f_reg && ta_f_reg && (tb_p_reg >= ta_p_reg);
                    o_last_next = 1'b1;
                    state_next = lobm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lobm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lobm_pkg::S_IDLE;
            valid_reg <= '0;
            arr_cnt_reg <= '0;
            rd_idx_reg <= '0;
            iss_reg <= 1'b0;
            dv_reg <= 1'b0;
            d_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            go_book_reg <= 1'b0;
            left_reg <= '0;
            filled_reg <= '0;
            qty_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            arr_cnt_reg <= arr_cnt_next;
            rd_idx_reg <= rd_idx_next;
            iss_reg <= iss_next;
            dv_reg <= dv_next;
            d_idx_reg <= d_idx_next;
            out_valid_reg <= out_valid_next;
            go_book_reg <= go_book_next;
            left_reg <= left_next;
            filled_reg <= filled_next;
            qty_reg <= qty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        id_reg <= id_next;
        side_reg <= side_next;
        price_reg <= price_next;
        ts_reg <= ts_next;
        stat_reg <= stat_next;
        fm_found_reg <= fm_found_next;
        fm_idx_reg <= fm_idx_next;
        fm_side_reg <= fm_side_next;
        bs_found_reg <= bs_found_next;
        bs_idx_reg <= bs_idx_next;
        bs_reg <= bs_next;
        bs_age_reg <= bs_age_next;
        tb_f_reg <= tb_f_next;
        tb_p_reg <= tb_p_next;
        tb_q_reg <= tb_q_next;
        ta_f_reg <= ta_f_next;
        ta_p_reg <= ta_p_next;
        ta_q_reg <= ta_q_next;
        o_stat_reg <= o_stat_next;
        o_maker_reg <= o_maker_next;
        o_tp_reg <= o_tp_next;
        o_tq_reg <= o_tq_next;
        o_tt_reg <= o_tt_next;
        o_fill_reg <= o_fill_next;
        o_bb_reg <= o_bb_next;
        o_ba_reg <= o_ba_next;
        o_bbq_reg <= o_bbq_next;
        o_baq_reg <= o_baq_next;
        o_cr_reg <= o_cr_next;
        o_last_reg <= o_last_next;
    end

    assign in_ready = (state_reg == lobm_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign status = o_stat_reg;
    assign maker_id = o_maker_reg;
    assign trade_price = o_tp_reg;
    assign trade_qty = o_tq_reg;
    assign trade_time = o_tt_reg;
    assign fill_total = o_fill_reg;
    assign best_bid = o_bb_reg;
    assign best_ask = o_ba_reg;
    assign best_bid_qty = o_bbq_reg;
    assign best_ask_qty = o_baq_reg;
    assign crossed = o_cr_reg;
    assign last = o_last_reg;

    `LOBM_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
    `LOBM_ASSERT_SAME(a_fill_sum, state_reg != lobm_pkg::S_IDLE,
        (({1'b0, left_reg} + {1'b0, filled_reg}) == {1'b0, qty_reg}))
    `LOBM_ASSERT_SAME(a_trade_word, out_valid_reg && !o_last_reg,
        o_stat_reg == lobm_pkg::ST_TRADE && o_tq_reg != '0)
endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench of the limit order book matcher: directed and random commands,
// a command-level book model for expected words, and random stalls on both channels.
// Depends on lobm_pkg and the limit_order_book_matcher RTL.
`timescale 1ns / 1ps
module testbench;
    localparam int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS;
    localparam logic [2:0] OP_ADD = lobm_pkg::OP_ADD;
    localparam logic [2:0] OP_CANCEL = lobm_pkg::OP_CANCEL;
    localparam logic [2:0] OP_MODIFY = lobm_pkg::OP_MODIFY;
    localparam logic [2:0] OP_MARKET = lobm_pkg::OP_MARKET;
    localparam logic [2:0] OP_IOC = lobm_pkg::OP_IOC;
    localparam logic [1:0] ST_DONE = lobm_pkg::ST_DONE;
    localparam logic [1:0] ST_REJECT = lobm_pkg::ST_REJECT;
    localparam logic [1:0] ST_TRADE = lobm_pkg::ST_TRADE;
    localparam logic [1:0] ST_FULL = lobm_pkg::ST_FULL;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [31:0] QTY_MAX = 32'hFFFF_FFFF;

    typedef struct {
        logic [2:0]  opcode;
        logic [63:0] ord_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [63:0] timestamp;
    } command_t;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] maker_id;
        logic [31:0] trade_price;
        logic [31:0] trade_qty;
        logic [63:0] trade_time;
        logic [31:0] fill_total;
        logic [31:0] best_bid;
        logic [31:0] best_ask;
        logic [31:0] best_bid_qty;
        logic [31:0] best_ask_qty;
        logic        crossed;
        logic        last;
    } book_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [63:0] ord_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [63:0] timestamp;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [63:0] maker_id;
    logic [31:0] trade_price;
    logic [31:0] trade_qty;
    logic [63:0] trade_time;
    logic [31:0] fill_total;
    logic [31:0] best_bid;
    logic [31:0] best_ask;
    logic [31:0] best_bid_qty;
    logic [31:0] best_ask_qty;
    logic        crossed;
    logic        last;

    limit_order_book_matcher dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .ord_id(ord_id), .side(side), .price(price),
        .quantity(quantity), .timestamp(timestamp),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .maker_id(maker_id), .trade_price(trade_price),
        .trade_qty(trade_qty), .trade_time(trade_time), .fill_total(fill_total),
        .best_bid(best_bid), .best_ask(best_ask), .best_bid_qty(best_bid_qty),
        .best_ask_qty(best_ask_qty), .crossed(crossed), .last(last)
    );

    command_t   pending_commands[$];
    book_word_t expected_words[$];
    int         total_commands;
    int         accepted_commands;
    int         trades_seen;
    int         closings_seen;
    int         error_count;
    int         sender_idle_pct;
    int         receiver_stall_pct;
    logic       hold_off;
    logic [63:0] id_pool[40];

    bit          book_valid[ORDER_SLOTS];
    logic [63:0] book_id[ORDER_SLOTS];
    logic        book_side[ORDER_SLOTS];
    logic [31:0] book_price[ORDER_SLOTS];
    logic [31:0] book_left[ORDER_SLOTS];
    logic [31:0] book_arrival[ORDER_SLOTS];
    logic [31:0] arrival_count;

    function automatic int find_order(logic [63:0] id);
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (book_valid[i] && book_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int best_order(logic rs, bit bounded, logic [31:0] bound);
        int best;
        logic [31:0] best_age;
        logic [31:0] age;
        bit better;
        best = -1;
        best_age = 0;
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            if (!book_valid[i] || book_side[i] != rs)
                continue;
            if (bounded && (rs ? (book_price[i] > bound) : (book_price[i] < bound)))
                continue;
            age = arrival_count - book_arrival[i];
            if (best < 0) begin
                best = i;
                best_age = age;
            end
            else begin
                better = rs ? (book_price[i] < book_price[best])
                            : (book_price[i] > book_price[best]);
                if (better || (book_price[i] == book_price[best] && age > best_age)) begin
                    best = i;
                    best_age = age;
                end
            end
        end
        return best;
    endfunction

    task automatic side_top(input logic rs, output logic [31:0] p, output logic [31:0] q);
        int b;
        logic [63:0] sum;
        b = best_order(rs, 0, 0);
        sum = 0;
        p = 0;
        q = 0;
        if (b >= 0) begin
            p = book_price[b];
            for (int i = 0; i < ORDER_SLOTS; i++)
                if (book_valid[i] && book_side[i] == rs && book_price[i] == p)
                    sum += book_left[i];
            q = (sum > 64'hFFFF_FFFF) ? QTY_MAX : sum[31:0];
        end
    endtask

    task automatic rest_order(int s, logic [63:0] id, logic sd, logic [31:0] p, logic [31:0] q);
        book_valid[s] = 1;
        book_id[s] = id;
        book_side[s] = sd;
        book_price[s] = p;
        book_left[s] = q;
        book_arrival[s] = arrival_count;
        arrival_count = arrival_count + 1;
    endtask

    task automatic book_model_step(input command_t c);
        book_word_t w;
        logic [1:0]  st;
        logic [31:0] filled;
        logic [31:0] left;
        logic [31:0] ex;
        int s;
        int m;
        st = ST_DONE;
        filled = 0;
        if (c.opcode == OP_ADD) begin
            if (c.quantity == 0 || find_order(c.ord_id) >= 0)
                st = ST_REJECT;
            else begin
                s = -1;
                for (int i = ORDER_SLOTS - 1; i >= 0; i--)
                    if (!book_valid[i])
                        s = i;
                if (s < 0)
                    st = ST_FULL;
                else
                    rest_order(s, c.ord_id, c.side, c.price, c.quantity);
            end
        end
        else if (c.opcode == OP_CANCEL) begin
            s = find_order(c.ord_id);
            if (s < 0)
                st = ST_REJECT;
            else
                book_valid[s] = 0;
        end
        else if (c.opcode == OP_MODIFY) begin
            s = find_order(c.ord_id);
            if (s < 0 || c.quantity == 0)
                st = ST_REJECT;
            else
                rest_order(s, c.ord_id, book_side[s], c.price, c.quantity);
        end
        else if (c.opcode == OP_MARKET || c.opcode == OP_IOC) begin
            left = c.quantity;
            while (left > 0) begin
                m = best_order(!c.side, c.opcode == OP_IOC, c.price);
                if (m < 0)
                    break;
                ex = (left < book_left[m]) ? left : book_left[m];
                w = '{default: '0};
                w.status = ST_TRADE;
                w.maker_id = book_id[m];
                w.trade_price = book_price[m];
                w.trade_qty = ex;
                w.trade_time = c.timestamp;
                expected_words.insert(expected_words.size(), w);
                book_left[m] -= ex;
                if (book_left[m] == 0)
                    book_valid[m] = 0;
                left -= ex;
                filled += ex;
            end
        end
        else
            st = ST_REJECT;
        w = '{default: '0};
        w.status = st;
        w.fill_total = filled;
        side_top(0, w.best_bid, w.best_bid_qty);
        side_top(1, w.best_ask, w.best_ask_qty);
        w.crossed = best_order(0, 0, 0) >= 0 && best_order(1, 0, 0) >= 0
                    && w.best_bid >= w.best_ask;
        w.last = 1;
        expected_words.insert(expected_words.size(), w);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic queue_command(logic [2:0] op, logic [63:0] id, logic sd,
                                 logic [31:0] p, logic [31:0] q);
        command_t c;
        c.opcode = op;
        c.ord_id = id;
        c.side = sd;
        c.price = p;
        c.quantity = q;
        c.timestamp = {$urandom, $urandom};
        pending_commands.insert(pending_commands.size(), c);
    endtask

    function automatic logic [2:0] random_opcode();
        int r;
        r = $urandom_range(99);
        if (r < 40) return OP_ADD;
        if (r < 52) return OP_CANCEL;
        if (r < 64) return OP_MODIFY;
        if (r < 80) return OP_MARKET;
        if (r < 97) return OP_IOC;
        return 3'($urandom_range(5, 7));
    endfunction

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        logic [31:0] p;
        logic [31:0] q;
        for (int i = 0; i < 40; i++)
            id_pool[i] = (i == 0) ? 64'd0 : (i == 1) ? '1 : {$urandom, $urandom};
        queue_command(OP_ADD, '1, 1, 32'd0, QTY_MAX);
        queue_command(OP_ADD, 64'd0, 0, QTY_MAX, QTY_MAX);
        queue_command(OP_ADD, 64'd0, 1, 32'd5, 32'd3);
        queue_command(OP_ADD, 64'd7, 0, 32'd5, 32'd0);
        queue_command(OP_CANCEL, 64'd99, 0, 0, 0);
        queue_command(OP_MODIFY, 64'd99, 1, 32'd5, 32'd5);
        queue_command(OP_MODIFY, '1, 0, 32'd5, 32'd0);
        queue_command(OP_MODIFY, '1, 0, 32'd20, 32'd9);
        queue_command(OP_MARKET, 64'd5, 0, 0, 32'd0);
        queue_command(OP_IOC, 64'd5, 0, 32'd10, 32'd4);
        queue_command(OP_IOC, 64'd5, 0, 32'd30, 32'd4);
        queue_command(OP_MARKET, 64'd5, 1, 0, QTY_MAX);
        queue_command(OP_UNUSED, 64'd5, 1, 0, 32'd1);
        queue_command(OP_ADD, 64'd11, 0, 32'd50, QTY_MAX);
        queue_command(OP_ADD, 64'd12, 0, 32'd50, QTY_MAX);
        queue_command(OP_ADD, 64'd13, 1, 32'd40, 32'd7);
        queue_command(OP_CANCEL, 64'd13, 1, 0, 0);
        for (int i = 0; i < ORDER_SLOTS + 1; i++)
            queue_command(OP_ADD, 64'd100 + i, i[0], 32'd60 + i[1:0], 32'd1 + i);
        queue_command(OP_IOC, 64'd1, 1, 32'd61, QTY_MAX);
        queue_command(OP_MARKET, 64'd1, 1, 0, QTY_MAX);
        queue_command(OP_MARKET, 64'd1, 0, 0, QTY_MAX);
        for (int n = 0; n < 407; n++) begin
            p = ($urandom_range(9) == 0) ? $urandom : $urandom_range(100, 108);
            q = ($urandom_range(15) == 0) ? $urandom
                : ($urandom_range(19) == 0) ? 32'd0 : $urandom_range(1, 60);
            queue_command(random_opcode(), id_pool[$urandom_range(39)],
                          1'($urandom_range(1)), p, q);
        end
        total_commands = pending_commands.size();
    end

    initial begin
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 0;
            opcode <= OP_ADD;
            ord_id <= 0;
            side <= 0;
            price <= 0;
            quantity <= 0;
            timestamp <= 0;
            accepted_commands <= 0;
            book_valid = '{default: 0};
            arrival_count = 0;
        end
        else begin
            if (in_valid && in_ready) begin
                book_model_step('{opcode, ord_id, side, price, quantity, timestamp});
                accepted_commands <= accepted_commands + 1;
            end
            if (!in_valid || in_ready) begin
                if (pending_commands.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    command_t c;
                    c = pending_commands.pop_front();
                    in_valid <= 1;
                    opcode <= c.opcode;
                    ord_id <= c.ord_id;
                    side <= c.side;
                    price <= c.price;
                    quantity <= c.quantity;
                    timestamp <= c.timestamp;
                end
                else
                    in_valid <= 0;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ready <= 0;
        else
            out_ready <= !hold_off && $urandom_range(99) >= receiver_stall_pct;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, status", status, 0);
            else begin
                book_word_t w;
                w = expected_words.pop_front();
                if (status != w.status) report_mismatch("status", status, w.status);
                if (maker_id != w.maker_id) report_mismatch("maker_id", maker_id, w.maker_id);
                if (trade_price != w.trade_price)
                    report_mismatch("trade_price", trade_price, w.trade_price);
                if (trade_qty != w.trade_qty) report_mismatch("trade_qty", trade_qty, w.trade_qty);
                if (trade_time != w.trade_time)
                    report_mismatch("trade_time", trade_time, w.trade_time);
                if (fill_total != w.fill_total)
                    report_mismatch("fill_total", fill_total, w.fill_total);
                if (best_bid != w.best_bid) report_mismatch("best_bid", best_bid, w.best_bid);
                if (best_ask != w.best_ask) report_mismatch("best_ask", best_ask, w.best_ask);
                if (best_bid_qty != w.best_bid_qty)
                    report_mismatch("best_bid_qty", best_bid_qty, w.best_bid_qty);
                if (best_ask_qty != w.best_ask_qty)
                    report_mismatch("best_ask_qty", best_ask_qty, w.best_ask_qty);
                if (crossed != w.crossed) report_mismatch("crossed", crossed, w.crossed);
                if (last != w.last) report_mismatch("last", last, w.last);
            end
            if (last)
                closings_seen++;
            else
                trades_seen++;
        end
    end

    // The sender and receiver idle rates step through phases as commands are accepted.
    always @(posedge clk) begin
        if (accepted_commands < 150) begin
            sender_idle_pct <= 0;
            receiver_stall_pct <= 0;
        end
        else if (accepted_commands < 260) begin
            sender_idle_pct <= 55;
            receiver_stall_pct <= 0;
        end
        else if (accepted_commands < 380) begin
            sender_idle_pct <= 0;
            receiver_stall_pct <= 55;
        end
        else begin
            sender_idle_pct <= 19;
            receiver_stall_pct <= 19;
        end
    end

    // The receiver holds off long enough for the block to stall its input.
    initial begin
        hold_off = 0;
        error_count = 0;
        trades_seen = 0;
        closings_seen = 0;
        wait (rst_n === 1'b1 && accepted_commands >= 120);
        @(posedge clk);
        hold_off <= 1;
        repeat (800) @(posedge clk);
        hold_off <= 0;
    end

    initial begin
        wait (rst_n === 1'b1 && total_commands > 0);
        while (accepted_commands < total_commands || expected_words.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Ran %0d commands through the book: %0d trade words and %0d closing words.",
                 accepted_commands, trades_seen, closings_seen);
        $display("Covered rejects, a full table, saturated depth, crossing and stalls.");
        if (error_count == 0 && expected_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d commands accepted.", accepted_commands);
        $display("FAILURE");
        $finish;
    end
endmodule
